@@ rtl/lcdcd_pkg.sv @@
// shared types and constants for the ganged lcd column driver bank
package lcdcd_pkg;

    localparam int DEF_NUM_CHIPS = 10;
    localparam int DEF_COLUMNS   = 50;
    localparam int PAGES         = 4;
    localparam int PAGE_W        = 2;
    localparam int COL_W         = 6;
    localparam int MEM_AW        = PAGE_W + COL_W;
    localparam int MEM_DEPTH     = 1 << MEM_AW;
    localparam int CS_W          = 10;

    typedef enum logic [2:0] {
        OP_CMD_WR    = 3'd0,
        OP_DATA_WR   = 3'd1,
        OP_STATUS_RD = 3'd2,
        OP_DATA_RD   = 3'd3,
        OP_SEL_LO    = 3'd4,
        OP_SEL_HI    = 3'd5
    } t_opcode;

    localparam logic [7:0] CMD_COUNT_DIR  = 8'h32;
    localparam logic [7:0] CMD_DISPLAY    = 8'h38;
    localparam logic [7:0] CMD_COUNT_INV  = 8'h3a;
    localparam logic [7:0] CMD_START_MASK = 8'h3e;
    localparam logic [7:0] STAT_DOWN      = 8'h40;
    localparam logic [7:0] STAT_ON        = 8'h20;
    localparam logic [7:0] STAT_BASE      = 8'h0f;
    localparam logic [7:0] NO_CHIP_READ   = 8'hff;

    typedef struct packed {
        logic       en;
        logic [2:0] op;
        logic [7:0] dat;
    } t_chip_req;

endpackage

@@ rtl/ganged_lcd_column_driver_bank.sv @@
// top level of the ganged lcd column driver bank
// Each accepted transfer passes an input register, then the per-chip registers
// (control state and the registered display memory read), then a result register;
// a new transfer can be taken every cycle unless the memory clear or a stalled output
// holds the input, and a status or data read reaches the output from the result
// register. After reset the display memories are cleared, one address per cycle over
// all 256 addresses with all chips in parallel, while the input is stalled.
module ganged_lcd_column_driver_bank #(
    parameter int NUM_CHIPS = lcdcd_pkg::DEF_NUM_CHIPS,
    parameter int COLUMNS   = lcdcd_pkg::DEF_COLUMNS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_bus_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data
);
    import lcdcd_pkg::*;

    logic [CS_W-1:0]      r_cs;
    logic                 r_clr_busy;
    logic [MEM_AW-1:0]    r_clr_addr;
    logic                 r_s1_vld;
    logic [2:0]           r_s1_op;
    logic [7:0]           r_s1_dat;
    logic                 r_s2_vld, r_s2_is_data;
    logic [NUM_CHIPS-1:0] r_s2_sel;
    logic [7:0]           r_s2_val;
    logic                 r_out_valid;
    logic [7:0]           r_out_data;
    logic                 advance, s1_go, s1_read;
    logic [7:0]           stat_and, data_and;
    logic [7:0]           rd_data [NUM_CHIPS];
    logic [7:0]           status  [NUM_CHIPS];
    t_chip_req            req     [NUM_CHIPS];

    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_clr_busy || !advance;
    assign s1_go      = r_s1_vld && advance;
    assign s1_read    = (r_s1_op == OP_STATUS_RD) || (r_s1_op == OP_DATA_RD);

    for (genvar c = 0; c < NUM_CHIPS; c++) begin : g_chip
        assign req[c] = '{en: s1_go && r_cs[c], op: r_s1_op, dat: r_s1_dat};
        lcdcd_chip #(.COLUMNS(COLUMNS)) u_chip (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_req     (req[c]),
            .i_clr_en  (r_clr_busy),
            .i_clr_addr(r_clr_addr),
            .o_rd_data (rd_data[c]),
            .o_status  (status[c])
        );
    end

    always_comb begin
        stat_and = NO_CHIP_READ;
        data_and = NO_CHIP_READ;
        for (int c = 0; c < NUM_CHIPS; c++) begin
            if (r_cs[c]) begin
                stat_and = stat_and & status[c];
            end
            if (r_s2_sel[c]) begin
                data_and = data_and & rd_data[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs        <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == {MEM_AW{1'b1}}) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (advance) begin
                r_s1_vld    <= i_in_valid && !r_clr_busy;
                r_s2_vld    <= r_s1_vld && s1_read;
                r_out_valid <= r_s2_vld;
            end
            if (s1_go) begin
                case (r_s1_op)
                    OP_SEL_LO: r_cs[7:0] <= r_s1_dat;
                    OP_SEL_HI: r_cs[9:8] <= r_s1_dat[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_op      <= i_opcode;
            r_s1_dat     <= i_bus_data;
            r_s2_is_data <= (r_s1_op == OP_DATA_RD);
            r_s2_sel     <= r_cs[NUM_CHIPS-1:0];
            r_s2_val     <= stat_and;
            r_out_data   <= r_s2_is_data ? data_and : r_s2_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    a_clr_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_in_stall) else $error("transfer accepted during memory clear");
    a_read_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_read) |=> r_s2_vld) else $error("read lost in pipeline");
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && !s1_read) |=> !r_s2_vld) else $error("result from non-read");
    a_none_selected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_s2_vld && r_s2_sel == '0 && r_s2_is_data) |=> (o_read_data == NO_CHIP_READ))
        else $error("read with no chip selected not all ones");

endmodule

@@ rtl/lcdcd_chip.sv @@
// one column driver chip: control state and its page/column display memory
module lcdcd_chip #(
    parameter int COLUMNS = lcdcd_pkg::DEF_COLUMNS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lcdcd_pkg::t_chip_req         i_req,
    input  logic                         i_clr_en,
    input  logic [lcdcd_pkg::MEM_AW-1:0] i_clr_addr,
    output logic [7:0]                   o_rd_data,
    output logic [7:0]                   o_status
);
    import lcdcd_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    logic [7:0]        r_mem [MEM_DEPTH];
    logic [7:0]        r_rd;
    logic [COL_W-1:0]  r_col, r_latch, n_col, n_step;
    logic [PAGE_W-1:0] r_page, r_start, n_page, n_start;
    logic              r_down, r_on, n_down, n_on;
    logic [COL_W-1:0]  cmd_col;

    always_comb begin
        if (!r_down) begin
            n_step = (r_col == LAST_COL) ? '0 : r_col + 1'b1;
        end else begin
            n_step = (r_col == '0) ? LAST_COL : r_col - 1'b1;
        end
    end

    assign cmd_col = (i_req.dat[COL_W-1:0] > LAST_COL) ? LAST_COL : i_req.dat[COL_W-1:0];

    always_comb begin
        n_col   = r_col;
        n_page  = r_page;
        n_start = r_start;
        n_down  = r_down;
        n_on    = r_on;
        if (i_req.en) begin
            case (i_req.op)
                OP_CMD_WR: begin
                    if (i_req.dat[7:1] == CMD_COUNT_DIR[7:1]) begin
                        n_down = i_req.dat[0];
                    end else if (i_req.dat[7:1] == CMD_DISPLAY[7:1]) begin
                        n_on = i_req.dat[0];
                    end else if (i_req.dat[7:1] == CMD_COUNT_INV[7:1]) begin
                        n_down = ~i_req.dat[0];
                    end else if ((i_req.dat & CMD_START_MASK) == CMD_START_MASK) begin
                        n_start = i_req.dat[7:6];
                    end else begin
                        n_page = i_req.dat[7:6];
                        n_col  = cmd_col;
                    end
                end
                OP_DATA_WR, OP_DATA_RD: n_col = n_step;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_latch <= '0;
            r_page  <= '0;
            r_start <= '0;
            r_down  <= 1'b0;
            r_on    <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_page  <= n_page;
            r_start <= n_start;
            r_down  <= n_down;
            r_on    <= n_on;
            if (i_req.en && i_req.op == OP_DATA_RD) begin
                r_latch <= r_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr_en) begin
            r_mem[i_clr_addr] <= '0;
        end else if (i_req.en && i_req.op == OP_DATA_WR) begin
            r_mem[{r_page, r_col}] <= i_req.dat;
        end
    end

    // read port: byte at the previously latched column
    always_ff @(posedge i_clk) begin
        if (i_req.en && i_req.op == OP_DATA_RD) begin
            r_rd <= r_mem[{r_page, r_latch}];
        end
    end

    assign o_rd_data = r_rd;
    assign o_status  = STAT_BASE | (r_down ? STAT_DOWN : 8'h00) | (r_on ? STAT_ON : 8'h00)
                     | {6'b0, r_start & 2'b00};

endmodule

@@ tb/lcdcd_checker.sv @@
// checker for the ganged lcd column driver bank: predicts read results and compares them
`timescale 1ns / 100ps
module lcdcd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_bus_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_read_data,
    output int         o_fail_count,
    output int         o_pending
);
    import lcdcd_pkg::*;

    localparam int NCH  = 10;
    localparam int NCOL = 50;

    logic [9:0] sel_mask;
    logic [7:0] lcd_mem [NCH][PAGES][NCOL];
    logic [5:0] col_ptr [NCH];
    logic [5:0] latch_col [NCH];
    logic [1:0] page_sel [NCH];
    logic [1:0] first_page [NCH];
    logic       down_cnt [NCH];
    logic       disp_on [NCH];
    logic [7:0] read_queue [$];
    int         fails;

    assign o_fail_count = fails;
    assign o_pending    = read_queue.size();

    function automatic logic [5:0] clamp_col(input logic [5:0] c);
        return (c < NCOL) ? c : 6'(NCOL - 1);
    endfunction

    task automatic advance_column(input int c);
        logic [5:0] p;
        p = clamp_col(col_ptr[c]);
        if (!down_cnt[c]) col_ptr[c] = (p >= NCOL - 1) ? 6'd0 : p + 6'd1;
        else col_ptr[c] = (p == 0) ? 6'(NCOL - 1) : p - 6'd1;
    endtask

    task automatic apply_bus_access(input logic [2:0] op, input logic [7:0] d);
        logic [7:0] acc;
        acc = NO_CHIP_READ;
        case (op)
            OP_CMD_WR: begin
                for (int c = 0; c < NCH; c++) if (sel_mask[c]) begin
                    if ((d & 8'hfe) == CMD_COUNT_DIR) down_cnt[c] = d[0];
                    else if ((d & 8'hfe) == CMD_DISPLAY) disp_on[c] = d[0];
                    else if ((d & 8'hfe) == CMD_COUNT_INV) down_cnt[c] = ~d[0];
                    else if ((d & CMD_START_MASK) == CMD_START_MASK) first_page[c] = d[7:6];
                    else begin
                        page_sel[c] = d[7:6];
                        col_ptr[c]  = clamp_col(d[5:0]);
                    end
                end
            end
            OP_DATA_WR: begin
                for (int c = 0; c < NCH; c++) if (sel_mask[c]) begin
                    lcd_mem[c][page_sel[c]][clamp_col(col_ptr[c])] = d;
                    advance_column(c);
                end
            end
            OP_STATUS_RD: begin
                for (int c = 0; c < NCH; c++) if (sel_mask[c])
                    acc &= (down_cnt[c] ? STAT_DOWN : 8'h00) | (disp_on[c] ? STAT_ON : 8'h00)
                           | STAT_BASE;
                read_queue.push_back(acc);
            end
            OP_DATA_RD: begin
                for (int c = 0; c < NCH; c++) if (sel_mask[c]) begin
                    acc &= lcd_mem[c][page_sel[c]][clamp_col(latch_col[c])];
                    latch_col[c] = clamp_col(col_ptr[c]);
                    advance_column(c);
                end
                read_queue.push_back(acc);
            end
            OP_SEL_LO: sel_mask[7:0] = d;
            OP_SEL_HI: sel_mask[9:8] = d[1:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            sel_mask = '0;
            for (int c = 0; c < NCH; c++) begin
                col_ptr[c] = '0; latch_col[c] = '0; page_sel[c] = '0;
                first_page[c] = '0; down_cnt[c] = 0; disp_on[c] = 0;
                for (int p = 0; p < PAGES; p++)
                    for (int k = 0; k < NCOL; k++) lcd_mem[c][p][k] = '0;
            end
            read_queue.delete();
            fails = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (read_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected read result %h", i_read_data);
                end else begin
                    want = read_queue.pop_front();
                    if (want !== i_read_data) begin
                        fails++;
                        if (fails <= 10)
                            $display("read_data mismatch: expected %h actual %h", want,
                                     i_read_data);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) apply_bus_access(i_opcode, i_bus_data);
        end
    end
endmodule

@@ tb/tb.sv @@
// testbench top: drives bus accesses into the lcd column driver bank and reports the verdict
`timescale 1ns / 100ps
module tb;
    import lcdcd_pkg::*;

    logic       clk, rst_n, in_valid, in_stall, out_valid, out_stall;
    logic [2:0] opcode;
    logic [7:0] bus_data, read_data;
    int         fail_count, pending;
    int         quiet_lo, quiet_hi, xfer_cnt;

    ganged_lcd_column_driver_bank dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_opcode(opcode), .i_bus_data(bus_data), .o_out_valid(out_valid),
        .i_out_stall(out_stall), .o_read_data(read_data)
    );

    lcdcd_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_opcode(opcode), .i_bus_data(bus_data), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_read_data(read_data), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic bit in_quiet_window();
        return xfer_cnt >= quiet_lo && xfer_cnt < quiet_hi;
    endfunction

    // receiver stalls at random, except inside the quiet window
    always @(negedge clk) begin
        if (!rst_n) out_stall <= 0;
        else out_stall <= !in_quiet_window() && ($urandom_range(99) < 6);
    end

    // one transfer: hold valid until accepted, with idle cycles inserted first at random outside the quiet window
    task automatic send_access(input logic [2:0] op, input logic [7:0] d);
        while (!in_quiet_window() && $urandom_range(99) < 6) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        opcode   <= op;
        bus_data <= d;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        xfer_cnt++;
    endtask

    task automatic random_access();
        int r;
        logic [7:0] d;
        r = $urandom_range(99);
        d = 8'($urandom);
        if (r < 3) send_access(3'($urandom_range(7, 6)), d);
        else if (r < 8) send_access(OP_SEL_LO, d);
        else if (r < 11) send_access(OP_SEL_HI, d);
        else if (r < 30) begin
            case ($urandom_range(4))
                0: d = {7'b0011001, d[0]};
                1: d = {7'b0011100, d[0]};
                2: d = {7'b0011101, d[0]};
                3: d = {d[7:6], 5'b11111, d[0]};
                default: ;
            endcase
            send_access(OP_CMD_WR, d);
        end
        else if (r < 58) send_access(OP_DATA_WR, d);
        else if (r < 68) send_access(OP_STATUS_RD, d);
        else send_access(OP_DATA_RD, d);
    endtask

    initial begin
        int tmo;
        rst_n = 0; in_valid = 0; opcode = '0; bus_data = '0;
        xfer_cnt = 0;
        quiet_lo = 600; quiet_hi = 800;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // directed: reads with nothing selected, then extremes and every command kind
        send_access(OP_STATUS_RD, 8'h00);
        send_access(OP_DATA_RD, 8'hff);
        send_access(OP_SEL_LO, 8'hff);
        send_access(OP_SEL_HI, 8'hff);
        send_access(OP_DATA_RD, 8'h00);
        send_access(OP_STATUS_RD, 8'h00);
        send_access(OP_CMD_WR, 8'h39);
        send_access(OP_CMD_WR, 8'h33);
        send_access(OP_STATUS_RD, 8'h00);
        send_access(OP_CMD_WR, 8'h3b);
        send_access(OP_CMD_WR, 8'hfe);
        send_access(OP_CMD_WR, 8'h3f);
        send_access(OP_CMD_WR, 8'hff);
        send_access(OP_DATA_WR, 8'hff);
        send_access(OP_DATA_WR, 8'h00);
        send_access(OP_CMD_WR, 8'hf1);
        send_access(OP_DATA_RD, 8'h00);
        send_access(OP_DATA_RD, 8'h00);
        send_access(OP_CMD_WR, 8'h3a);
        send_access(OP_DATA_WR, 8'ha5);
        send_access(OP_CMD_WR, 8'h38);
        send_access(OP_STATUS_RD, 8'h00);
        send_access(3'd6, 8'h55);
        send_access(3'd7, 8'haa);
        send_access(OP_SEL_HI, 8'hfc);
        for (int i = 0; i < 1300; i++) random_access();
        in_valid <= 0;
        tmo = 0;
        while (pending != 0 && tmo < 10000) begin
            @(posedge clk);
            tmo++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) $display("ganged_lcd_column_driver_bank verification clean");
        else $display("ganged_lcd_column_driver_bank verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("ganged_lcd_column_driver_bank verification failed");
        $finish;
    end
endmodule
